// ===== hdl/scqs_pkg.sv =====
`timescale 1ns / 1ps

package scqs_pkg;

    localparam int QUEUE_DEPTH = 64;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH);
    localparam int FREE_W      = 7;
    localparam int CMD_W       = 17;
    localparam int IN_DATA_W   = 24;
    localparam int OUT_DATA_W  = 16;

    localparam logic ACT_PUSH = 1'b0;
    localparam logic ACT_TICK = 1'b1;

    typedef struct packed {
        logic       dir;
        logic [7:0] count;
        logic [7:0] delay;
    } cmd_t;

    typedef struct packed {
        logic push;
        logic pop;
        cmd_t push_cmd;
    } queue_ctrl_t;

    typedef struct packed {
        cmd_t              head_cmd;
        logic              empty;
        logic              full;
        logic [FREE_W-1:0] free_after;
    } queue_stat_t;

    function automatic logic [3:0] coil_pattern(input logic [1:0] phase);
        logic [3:0] pat;
        unique case (phase)
            2'd0:    pat = 4'h9;
            2'd1:    pat = 4'h5;
            2'd2:    pat = 4'h6;
            default: pat = 4'hA;
        endcase
        return pat;
    endfunction

endpackage

// ===== hdl/scqs_cmd_queue.sv =====
`timescale 1ns / 1ps

module scqs_cmd_queue (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  scqs_pkg::queue_ctrl_t ctrl,
    output scqs_pkg::queue_stat_t stat
);
    import scqs_pkg::*;

    cmd_t             mem [QUEUE_DEPTH];
    cmd_t             head_cmd_reg;
    logic [PTR_W-1:0] head_reg, head_next;
    logic [PTR_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             empty, full, do_push;

    function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign empty   = (count_reg == '0);
    assign full    = (count_reg == CNT_W'(QUEUE_DEPTH - 1));
    assign do_push = ctrl.push && !full;

    always_comb begin
        head_next  = ctrl.pop ? wrap_inc(head_reg) : head_reg;
        tail_next  = do_push ? wrap_inc(tail_reg) : tail_reg;
        count_next = count_reg;
        if (do_push) begin
            count_next = count_reg + 1'b1;
        end else if (ctrl.pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end else begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[tail_reg] <= ctrl.push_cmd;
        end
    end

    // head entry is prefetched from mem[head_next] into a register; a push into the slot being fetched is forwarded
    always_ff @(posedge aclk) begin
        if (do_push && (tail_reg == head_next)) begin
            head_cmd_reg <= ctrl.push_cmd;
        end else begin
            head_cmd_reg <= mem[head_next];
        end
    end

    assign stat.head_cmd   = head_cmd_reg;
    assign stat.empty      = empty;
    assign stat.full       = full;
    assign stat.free_after = FREE_W'(QUEUE_DEPTH) - FREE_W'(count_next);

`ifndef NO_ASSERTIONS
    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.pop |-> !empty)
        else $error("pop from empty command queue");

    a_push_not_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctrl.push && !full) |=> !empty)
        else $error("queue empty after accepted push");

    a_forward: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctrl.push && empty) |=> (head_cmd_reg == $past(ctrl.push_cmd)))
        else $error("head entry missed push into empty queue");

    a_ptr_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        empty |-> (head_reg == tail_reg))
        else $error("pointers differ on empty queue");
`endif

endmodule

// ===== hdl/stepper_command_queue_sequencer_top.sv =====
`timescale 1ns / 1ps

// stepper drive sequencer with a queue of motion commands
// input channel s_: s_tuser = 0 pushes the command in s_tdata, s_tuser = 1 is one time tick
// output channel m_: one result item per input item, in order
// the first tick on a queued command enables the driver and takes the first step, but a zero
// step count is popped on that tick with no step; otherwise the command then waits its delay in
// ticks after each step and is popped on the tick after the last wait, which disables the driver
// a push onto a full queue (63 commands held) is refused and flagged in the result
// the result is registered and is presented in the cycle after its item is accepted
// throughput: one item per cycle while the receiver does not stall, set by the single result
// register; the queue head is prefetched from the command memory into a register, so a tick never waits for it
// a stalled receiver holds the result; a new item is taken in the cycle the result leaves
// reset clears pointers, phase and motion state; the command memory is not cleared

module stepper_command_queue_sequencer_top (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // forward [0], step_count [8:1], step_delay [16:9], zero fill
    input  logic [scqs_pkg::IN_DATA_W-1:0]  s_tdata,
    // action
    input  logic                            s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // coil_pattern [3:0], driver_enable [4], free_slots [11:5], dropped [12], zero fill
    output logic [scqs_pkg::OUT_DATA_W-1:0] m_tdata
);
    import scqs_pkg::*;

    logic              accept, is_tick;
    cmd_t              in_cmd;
    queue_ctrl_t       qctrl;
    queue_stat_t       qstat;

    logic              running_reg, running_next;
    logic [7:0]        steps_left_reg, steps_left_next;
    logic [7:0]        wait_left_reg, wait_left_next;
    logic              dir_reg, dir_next;
    logic [7:0]        delay_reg, delay_next;
    logic [1:0]        phase_reg, phase_next;
    logic              step;
    logic              m_tvalid_reg;
    logic [OUT_DATA_W-1:0] m_tdata_reg;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign is_tick  = (s_tuser == ACT_TICK);

    assign in_cmd.dir   = s_tdata[0];
    assign in_cmd.count = s_tdata[8:1];
    assign in_cmd.delay = s_tdata[16:9];

    always_comb begin
        running_next    = running_reg;
        steps_left_next = steps_left_reg;
        wait_left_next  = wait_left_reg;
        dir_next        = dir_reg;
        delay_next      = delay_reg;
        step            = 1'b0;
        qctrl.push      = accept && !is_tick;
        qctrl.pop       = 1'b0;
        qctrl.push_cmd  = in_cmd;
        if (accept && is_tick) begin
            if (!running_reg) begin
                if (!qstat.empty) begin
                    dir_next   = qstat.head_cmd.dir;
                    delay_next = qstat.head_cmd.delay;
                    if (qstat.head_cmd.count == 8'd0) begin
                        qctrl.pop = 1'b1;
                    end else begin
                        running_next    = 1'b1;
                        step            = 1'b1;
                        steps_left_next = qstat.head_cmd.count - 8'd1;
                        wait_left_next  = qstat.head_cmd.delay;
                    end
                end
            end else if (wait_left_reg != 8'd0) begin
                wait_left_next = wait_left_reg - 8'd1;
            end else if (steps_left_reg != 8'd0) begin
                step            = 1'b1;
                steps_left_next = steps_left_reg - 8'd1;
                wait_left_next  = delay_reg;
            end else begin
                running_next = 1'b0;
                qctrl.pop    = 1'b1;
            end
        end
        // a freshly loaded command steps in its own direction
        if (step) begin
            phase_next = dir_next ? phase_reg + 2'd1 : phase_reg - 2'd1;
        end else begin
            phase_next = phase_reg;
        end
    end

    scqs_cmd_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (qctrl),
        .stat    (qstat)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            running_reg    <= 1'b0;
            steps_left_reg <= '0;
            wait_left_reg  <= '0;
            dir_reg        <= 1'b0;
            delay_reg      <= '0;
            phase_reg      <= '0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            running_reg    <= running_next;
            steps_left_reg <= steps_left_next;
            wait_left_reg  <= wait_left_next;
            dir_reg        <= dir_next;
            delay_reg      <= delay_next;
            phase_reg      <= phase_next;
            if (accept) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_tdata_reg <= {3'b000,
                            qctrl.push && qstat.full,
                            qstat.free_after,
                            running_next,
                            coil_pattern(phase_next)};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef NO_ASSERTIONS
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> $stable(m_tdata))
        else $error("result changed while stalled");

    a_idle_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        !running_reg |-> (steps_left_next == steps_left_reg || running_next || qctrl.pop))
        else $error("step counter moved while idle");

    a_start_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (!running_reg && running_next) |-> step)
        else $error("command started without a step");
`endif

endmodule

// ===== sim/tb_stepper_command_queue_sequencer_top.sv =====
`timescale 1ns / 1ps

module tb_stepper_command_queue_sequencer_top;

    import scqs_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_ITEMS = 1400;
    localparam int IDLE_PCT     = 12;

    typedef struct packed {
        logic [2:0]        fill;
        logic              dropped;
        logic [FREE_W-1:0] free_slots;
        logic              enable;
        logic [3:0]        coil;
    } drive_status_t;

    class stepper_scoreboard;
        cmd_t          cmd_ring [QUEUE_DEPTH];
        int            head;
        int            tail;
        logic [1:0]    phase;
        bit            running;
        logic [7:0]    steps_left;
        logic [7:0]    wait_left;
        bit            active_dir;
        logic [7:0]    active_delay;
        logic [3:0]    coil_lut [4];
        drive_status_t status_q [$];
        int            errors;

        function new();
            head         = 0;
            tail         = 0;
            phase        = 2'd0;
            running      = 1'b0;
            steps_left   = '0;
            wait_left    = '0;
            active_dir   = 1'b0;
            active_delay = '0;
            errors       = 0;
            coil_lut     = '{4'h9, 4'h5, 4'h6, 4'hA};
        endfunction

        function int advance(int ptr);
            return (ptr == QUEUE_DEPTH - 1) ? 0 : ptr + 1;
        endfunction

        function void step_phase();
            phase = active_dir ? phase + 2'd1 : phase - 2'd1;
        endfunction

        // works out the drive status after one accepted item
        function void note_item(logic act, logic [IN_DATA_W-1:0] data);
            drive_status_t res;
            cmd_t          cmd;
            int            used;
            res = '0;
            if (act == ACT_PUSH) begin
                if (advance(tail) == head) begin
                    res.dropped = 1'b1;
                end else begin
                    cmd.dir        = data[0];
                    cmd.count      = data[8:1];
                    cmd.delay      = data[16:9];
                    cmd_ring[tail] = cmd;
                    tail           = advance(tail);
                end
            end else if (!running) begin
                if (head != tail) begin
                    cmd          = cmd_ring[head];
                    active_dir   = cmd.dir;
                    active_delay = cmd.delay;
                    if (cmd.count == 8'd0) begin
                        head = advance(head);
                    end else begin
                        running = 1'b1;
                        step_phase();
                        steps_left = cmd.count - 8'd1;
                        wait_left  = active_delay;
                    end
                end
            end else if (wait_left != 8'd0) begin
                wait_left--;
            end else if (steps_left != 8'd0) begin
                step_phase();
                steps_left--;
                wait_left = active_delay;
            end else begin
                running = 1'b0;
                head    = advance(head);
            end
            used           = (tail >= head) ? tail - head : tail + QUEUE_DEPTH - head;
            res.coil       = coil_lut[phase];
            res.enable     = running;
            res.free_slots = FREE_W'(QUEUE_DEPTH - used);
            status_q.push_back(res);
        endfunction

        function void check_result(logic [OUT_DATA_W-1:0] data);
            drive_status_t want;
            drive_status_t got;
            got = data;
            if (status_q.size() == 0) begin
                $display("%0t unexpected result: expected none actual %h", $time, data);
                errors++;
                return;
            end
            want = status_q.pop_front();
            if (data[OUT_DATA_W-1:13] != '0) begin
                $display("%0t fill bits: expected 0 actual %h", $time, data[OUT_DATA_W-1:13]);
                errors++;
            end
            if (got.coil != want.coil) begin
                $display("%0t coil_pattern: expected %h actual %h", $time, want.coil, got.coil);
                errors++;
            end
            if (got.enable != want.enable) begin
                $display("%0t driver_enable: expected %b actual %b", $time, want.enable,
                         got.enable);
                errors++;
            end
            if (got.free_slots != want.free_slots) begin
                $display("%0t free_slots: expected %0d actual %0d", $time, want.free_slots,
                         got.free_slots);
                errors++;
            end
            if (got.dropped != want.dropped) begin
                $display("%0t dropped: expected %b actual %b", $time, want.dropped,
                         got.dropped);
                errors++;
            end
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata  = '0;
    logic                  s_tuser  = ACT_TICK;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;

    stepper_scoreboard     sb = new();
    bit                    steady_run = 1'b0;
    int                    cycle_count = 0;

    stepper_command_queue_sequencer_top DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    always @(posedge aclk) begin
        m_tready <= steady_run || ($urandom_range(99) >= IDLE_PCT);
    end

    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready)
            sb.note_item(s_tuser, s_tdata);
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tdata);
    end

    task automatic send_item(input logic act, input logic fwd, input logic [7:0] cnt,
                             input logic [7:0] dly);
        if (!steady_run && $urandom_range(99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {7'd0, dly, cnt, fwd};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // mostly short commands so the queue keeps draining, now and then a long one
    task automatic push_random_command();
        logic [7:0] cnt;
        logic [7:0] dly;
        int         pick;
        pick = $urandom_range(99);
        if (pick < 70) begin
            cnt = 8'($urandom_range(4));
            dly = 8'($urandom_range(3));
        end else if (pick < 97) begin
            cnt = 8'($urandom_range(20));
            dly = 8'($urandom_range(10));
        end else if (pick < 99) begin
            cnt = 8'd255 - 8'($urandom_range(3));
            dly = 8'($urandom_range(1));
        end else begin
            cnt = 8'($urandom_range(2, 1));
            dly = 8'd255 - 8'($urandom_range(3));
        end
        send_item(ACT_PUSH, 1'($urandom_range(1)), cnt, dly);
    endtask

    initial begin
        int push_pct;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // tick on an empty idle queue changes nothing
        send_item(ACT_TICK, 1'b0, 8'd0, 8'd0);
        // zero step count is popped on load without a step
        send_item(ACT_PUSH, 1'b0, 8'd0, 8'd255);
        send_item(ACT_TICK, 1'b1, 8'hFF, 8'hFF);
        // zero delay, forward, then reverse with a short wait
        send_item(ACT_PUSH, 1'b1, 8'd3, 8'd0);
        send_item(ACT_PUSH, 1'b0, 8'd2, 8'd1);
        repeat (9) send_item(ACT_TICK, 1'($urandom_range(1)), 8'($urandom_range(255)),
                             8'($urandom_range(255)));
        // tick fields are ignored
        send_item(ACT_TICK, 1'b1, 8'hFF, 8'hFF);
        send_item(ACT_PUSH, 1'b1, 8'd1, 8'd0);
        send_item(ACT_TICK, 1'b0, 8'h00, 8'h00);
        // extremes left for the random part to drain
        send_item(ACT_PUSH, 1'b0, 8'd255, 8'd0);
        send_item(ACT_PUSH, 1'b1, 8'd1, 8'd255);
        send_item(ACT_PUSH, 1'b1, 8'd170, 8'd0);
        send_item(ACT_PUSH, 1'b0, 8'd1, 8'd85);

        // alternate fill and drain phases so the full queue is reached repeatedly
        push_pct = 75;
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i % 150 == 0)
                push_pct = (push_pct == 75) ? 15 : 75;
            steady_run = (i >= 500 && i < 800);
            if ($urandom_range(99) < push_pct)
                push_random_command();
            else
                send_item(ACT_TICK, 1'($urandom_range(1)), 8'($urandom_range(255)),
                          8'($urandom_range(255)));
        end
        s_tvalid   <= 1'b0;
        steady_run = 1'b0;

        do @(posedge aclk); while (sb.status_q.size() != 0);
        repeat (8) @(posedge aclk);
        if (sb.errors == 0 && sb.status_q.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
